// ===== rtl/sld_pkg.sv =====
package sld_pkg;

  localparam int unsigned NUM_COMS   = 4;
  localparam int unsigned WORD_W     = 30;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned NUM_POS    = 8;
  localparam int unsigned PIN_W      = 5;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned COUNT_W    = 8;

  typedef logic [NUM_COMS-1:0][WORD_W-1:0] words_t;
  typedef logic [MASK_W-1:0]               glyph_t;
  typedef logic [POS_W-1:0]                pos_t;
  typedef logic [PIN_W-1:0]                pin_t;
  typedef logic [DIGIT_W-1:0]              digit_t;
  typedef logic [COUNT_W-1:0]              count_t;

  typedef enum logic {
    OP_SHOW_TIME = 1'b0,
    OP_RAW_GLYPH = 1'b1
  } op_t;

  typedef struct packed {
    digit_t hour_tens;
    digit_t hour_ones;
    digit_t min_tens;
    digit_t min_ones;
  } digits_t;

  localparam glyph_t COLON_GLYPH = 16'h8000;

  // Fixed positions written by a time update.
  localparam pos_t POS_HOUR_TENS = 3'd0;
  localparam pos_t POS_HOUR_ONES = 3'd1;
  localparam pos_t POS_COLON     = 3'd2;
  localparam pos_t POS_MIN_TENS  = 3'd4;
  localparam pos_t POS_MIN_ONES  = 3'd5;

  // Four pins owned by each digit position.
  localparam pin_t PIN_A [NUM_POS] = '{5'd0,  5'd2,  5'd8,  5'd10, 5'd12, 5'd14, 5'd16, 5'd18};
  localparam pin_t PIN_B [NUM_POS] = '{5'd1,  5'd7,  5'd9,  5'd11, 5'd13, 5'd15, 5'd17, 5'd19};
  localparam pin_t PIN_C [NUM_POS] = '{5'd29, 5'd27, 5'd25, 5'd21, 5'd19, 5'd16, 5'd15, 5'd13};
  localparam pin_t PIN_D [NUM_POS] = '{5'd28, 5'd26, 5'd24, 5'd20, 5'd18, 5'd17, 5'd14, 5'd12};

  // Seven-segment style glyphs for the decimal digits; anything else is blank.
  function automatic glyph_t digit_glyph(digit_t d);
    glyph_t g;
    case (d)
      4'd0:    g = 16'h003F;
      4'd1:    g = 16'h0006;
      4'd2:    g = 16'h045B;
      4'd3:    g = 16'h044F;
      4'd4:    g = 16'h0466;
      4'd5:    g = 16'h046D;
      4'd6:    g = 16'h047D;
      4'd7:    g = 16'h2201;
      4'd8:    g = 16'h047F;
      4'd9:    g = 16'h046F;
      default: g = '0;
    endcase
    return g;
  endfunction

  // Optionally clears the position's pins in every common word, then ORs the
  // glyph bits in through the pin map.
  function automatic words_t place_glyph(words_t w, pos_t pos, glyph_t m, logic clr);
    logic [WORD_W-1:0] da;
    logic [WORD_W-1:0] db;
    logic [WORD_W-1:0] dc;
    logic [WORD_W-1:0] dd;
    logic [WORD_W-1:0] own;
    words_t            r;
    da  = WORD_W'(1) << PIN_A[pos];
    db  = WORD_W'(1) << PIN_B[pos];
    dc  = WORD_W'(1) << PIN_C[pos];
    dd  = WORD_W'(1) << PIN_D[pos];
    own = da | db | dc | dd;
    r   = w;
    if (clr) begin
      for (int k = 0; k < NUM_COMS; k++) begin
        r[k] = r[k] & ~own;
      end
    end
    r[0] = r[0] | ({WORD_W{m[1]}} & dd) | ({WORD_W{m[4]}} & da)
                | ({WORD_W{m[6]}} & dc) | ({WORD_W{m[10]}} & db);
    r[1] = r[1] | ({WORD_W{m[0]}} & dd) | ({WORD_W{m[2]}} & db)
                | ({WORD_W{m[3]}} & da) | ({WORD_W{m[5]}} & dc);
    r[2] = r[2] | ({WORD_W{m[9]}} & dd) | ({WORD_W{m[12]}} & da)
                | ({WORD_W{m[13]}} & dc) | ({WORD_W{m[15]}} & db);
    r[3] = r[3] | ({WORD_W{m[7]}} & dc) | ({WORD_W{m[8]}} & dd)
                | ({WORD_W{m[11]}} & da) | ({WORD_W{m[14]}} & db);
    return r;
  endfunction

endpackage

// ===== rtl/sld_if.sv =====
interface sld_in_if;
  import sld_pkg::*;

  logic   valid;
  logic   ready;
  op_t    operation;
  count_t hours;
  count_t minutes;
  pos_t   position;
  glyph_t glyph_mask;
  logic   clear_first;

  modport source (output valid, operation, hours, minutes, position, glyph_mask, clear_first,
                  input ready);
  modport sink   (input valid, operation, hours, minutes, position, glyph_mask, clear_first,
                  output ready);
endinterface

interface sld_out_if;
  import sld_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] com0_word;
  logic [WORD_W-1:0] com1_word;
  logic [WORD_W-1:0] com2_word;
  logic [WORD_W-1:0] com3_word;
  logic              update_request;

  modport source (output valid, com0_word, com1_word, com2_word, com3_word, update_request,
                  input ready);
  modport sink   (input valid, com0_word, com1_word, com2_word, com3_word, update_request,
                  output ready);
endinterface

// ===== rtl/sld_time_digits.sv =====
module sld_time_digits (
  input  sld_pkg::count_t  hours,
  input  sld_pkg::count_t  minutes,
  output sld_pkg::digits_t digits
);
  import sld_pkg::*;

  count_t h1, h2, h3, h4;
  count_t m1, m2, m3;
  count_t r1, r2, r3;
  digit_t mt;

  // Hours modulo 24 by restoring subtraction of 192, 96, 48 and 24.
  always_comb begin
    h1 = (hours >= 8'd192) ? hours - 8'd192 : hours;
    h2 = (h1 >= 8'd96) ? h1 - 8'd96 : h1;
    h3 = (h2 >= 8'd48) ? h2 - 8'd48 : h2;
    h4 = (h3 >= 8'd24) ? h3 - 8'd24 : h3;
  end

  // Minutes modulo 60 by subtraction of 240, 120 and 60.
  always_comb begin
    m1 = (minutes >= 8'd240) ? minutes - 8'd240 : minutes;
    m2 = (m1 >= 8'd120) ? m1 - 8'd120 : m1;
    m3 = (m2 >= 8'd60) ? m2 - 8'd60 : m2;
  end

  // Tens digit of the minutes, one bit at a time.
  always_comb begin
    mt = '0;
    r1 = m3;
    if (r1 >= 8'd40) begin
      r1    = r1 - 8'd40;
      mt[2] = 1'b1;
    end
    r2 = r1;
    if (r2 >= 8'd20) begin
      r2    = r2 - 8'd20;
      mt[1] = 1'b1;
    end
    r3 = r2;
    if (r3 >= 8'd10) begin
      r3    = r3 - 8'd10;
      mt[0] = 1'b1;
    end
  end

  always_comb begin
    if (h4 >= 8'd20) begin
      digits.hour_tens = 4'd2;
      digits.hour_ones = h4[DIGIT_W-1:0] - 4'd4;
    end else if (h4 >= 8'd10) begin
      digits.hour_tens = 4'd1;
      digits.hour_ones = h4[DIGIT_W-1:0] - 4'd10;
    end else begin
      digits.hour_tens = 4'd0;
      digits.hour_ones = h4[DIGIT_W-1:0];
    end
    digits.min_tens = mt;
    digits.min_ones = r3[DIGIT_W-1:0];
  end

endmodule

// ===== rtl/segment_lcd_clock_display.sv =====
// Segment LCD clock display: keeps the four common-line words of a segment
// LCD controller's display RAM and updates them one request at a time.
// The input channel carries a request: either a time (hours and minutes,
// reduced to a 24-hour clock) that redraws positions 0, 1, 4, 5 and the
// colon at position 2, or a raw glyph mask written at one position, with an
// optional clear of that position's pins first.
// Every request gives exactly one result transfer holding all four words
// after the update and an update-request flag that is set only for a time.
// A request taken in is held in an input register, and the words are then
// computed from it and registered in the result register, where the result
// becomes valid. One request per cycle is sustained while the receiver takes
// results; the single register stage that updates the words sets the rate.
// When the receiver stalls, the result holds and the input register still
// takes one more request; after that in_ch.ready drops until the result is
// taken. Reset clears all four words to zero and empties both stages.
module segment_lcd_clock_display (
  input logic clk,
  input logic rst_n,
  sld_in_if.sink    in_ch,
  sld_out_if.source out_ch
);
  import sld_pkg::*;

  // Input stage.
  logic   s1_valid_r;
  op_t    s1_op_r;
  count_t s1_hours_r;
  count_t s1_minutes_r;
  pos_t   s1_pos_r;
  glyph_t s1_mask_r;
  logic   s1_clr_r;

  // Result stage. The words register is both the display state and the
  // result payload: it only changes when a new result is loaded.
  logic   out_valid_r;
  logic   upd_r;
  words_t words_r;
  words_t words_nxt;

  digits_t digits;
  logic    advance;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;

  sld_time_digits u_digits (
    .hours   (s1_hours_r),
    .minutes (s1_minutes_r),
    .digits  (digits)
  );

  always_comb begin
    words_t w;
    w = words_r;
    if (s1_op_r == OP_SHOW_TIME) begin
      w = place_glyph(w, POS_HOUR_TENS, digit_glyph(digits.hour_tens), 1'b1);
      w = place_glyph(w, POS_HOUR_ONES, digit_glyph(digits.hour_ones), 1'b1);
      w = place_glyph(w, POS_COLON, COLON_GLYPH, 1'b1);
      w = place_glyph(w, POS_MIN_TENS, digit_glyph(digits.min_tens), 1'b1);
      w = place_glyph(w, POS_MIN_ONES, digit_glyph(digits.min_ones), 1'b1);
    end else begin
      w = place_glyph(w, s1_pos_r, s1_mask_r, s1_clr_r);
    end
    words_nxt = w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r      <= in_ch.operation;
      s1_hours_r   <= in_ch.hours;
      s1_minutes_r <= in_ch.minutes;
      s1_pos_r     <= in_ch.position;
      s1_mask_r    <= in_ch.glyph_mask;
      s1_clr_r     <= in_ch.clear_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      words_r     <= '0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        words_r <= words_nxt;
      end
    end
    if (advance && s1_valid_r) begin
      upd_r <= (s1_op_r == OP_SHOW_TIME);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.com0_word      = words_r[0];
  assign out_ch.com1_word      = words_r[1];
  assign out_ch.com2_word      = words_r[2];
  assign out_ch.com3_word      = words_r[3];
  assign out_ch.update_request = upd_r;

endmodule
